// ----- hw/rtl/slrg_pkg.sv -----
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared types, constants and helpers for the subtractive lagged generator.
// ----------------------------------------------------------------------------
package slrg_pkg;

    localparam int VAL_W     = 30;
    localparam int SEED_W    = 31;
    localparam int TBL_LEN   = 55;
    localparam int LAG       = 31;
    localparam int JUMP      = 21;

    localparam logic [VAL_W-1:0]  MODULUS   = 30'd1000000000;
    localparam logic [SEED_W-1:0] SEED_BASE = 31'd161803398;

    typedef logic [VAL_W-1:0] val_t;

    // cell operation codes
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD = 2'd0;
    localparam cell_op_t CELL_STEP = 2'd1;
    localparam cell_op_t CELL_JUMP = 2'd2;

    // a - b wrapped into 0..modulus-1
    function automatic val_t sub_wrap(input val_t a, input val_t b);
        logic [VAL_W:0] d;
        begin
            d = {1'b0, a} - {1'b0, b};
            if (d[VAL_W])
            begin
                d = d + {1'b0, MODULUS};
            end
            return d[VAL_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/slrg_if.sv -----
// ----------------------------------------------------------------------------
// slrg_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface slrg_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [slrg_pkg::SEED_W-1:0] seed_value;

    modport source (output valid, output req_type, output seed_value, input ready);
    modport sink   (input valid, input req_type, input seed_value, output ready);
endinterface

interface slrg_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [slrg_pkg::VAL_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

// ----- hw/rtl/slrg_cell.sv -----
// ----------------------------------------------------------------------------
// slrg_cell
// One table entry of the ring: holds, takes its next neighbor, or takes the
// entry that sits a fixed jump further along the ring.
// ----------------------------------------------------------------------------
module slrg_cell (
    input  logic               clk,
    input  slrg_pkg::cell_op_t op,
    input  slrg_pkg::val_t     d_step,
    input  slrg_pkg::val_t     d_jump,
    output slrg_pkg::val_t     q
);

    slrg_pkg::val_t val_reg;
    slrg_pkg::val_t val_next;

    // select the incoming entry
    always_comb
    begin
        case (op)
            slrg_pkg::CELL_STEP: val_next = d_step;
            slrg_pkg::CELL_JUMP: val_next = d_jump;
            default:             val_next = val_reg;
        endcase
    end

    // entry storage, undefined until written
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign q = val_reg;

endmodule

// ----- hw/rtl/subtractive_lagged_random_generator.sv -----
// ----------------------------------------------------------------------------
// subtractive_lagged_random_generator
// Subtractive lagged generator over a 55-entry ring of cells, values mod 10^9.
// ----------------------------------------------------------------------------
//  channel | dir | fields                     | word
//  req     | in  | req_type, seed_value       | one draw or reseed-and-draw
//  rsp     | out | random_value               | one value per request
//
//  A draw rotates the ring by one: cell 0 minus cell 31 enters at the
//  tail and is registered as the result.
//  A reseed (or the first request after reset) runs 55 fill
//  steps rotating by 21, two alignment steps, 220 warm-up steps, one draw.
//  Reset clears control state only; the ring contents stay unknown.
//  A new request is taken in the idle state once the result register is free or being taken.
// ----------------------------------------------------------------------------
module subtractive_lagged_random_generator (
    input logic       clk,
    input logic       rst_n,
    slrg_req_if.sink  req,
    slrg_rsp_if.source rsp
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_ALNJ  = 3'd2;
    localparam logic [2:0] ST_ALNS  = 3'd3;
    localparam logic [2:0] ST_WARM  = 3'd4;
    localparam logic [2:0] ST_DRAW  = 3'd5;

    localparam logic [7:0] FILL_LAST = 8'(slrg_pkg::TBL_LEN - 1);
    localparam logic [7:0] WARM_LAST = 8'(4 * slrg_pkg::TBL_LEN - 1);

    logic [2:0]         state_reg, state_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic               seeded_reg, seeded_next;
    logic               out_valid_reg, out_valid_next;
    slrg_pkg::val_t     out_data_reg;
    slrg_pkg::val_t     cur_reg, nxt_reg;
    slrg_pkg::val_t     cur0;
    logic [slrg_pkg::SEED_W-1:0] diff;

    slrg_pkg::val_t     cells [slrg_pkg::TBL_LEN];
    slrg_pkg::cell_op_t op;
    slrg_pkg::val_t     tail_d, head_d, draw_val;
    logic               out_free, accept, need_seed, load_out;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign need_seed = req.req_type || !seeded_reg;
    assign draw_val  = slrg_pkg::sub_wrap(cells[0], cells[slrg_pkg::LAG]);

    // seed start value |base - seed| mod 10^9
    always_comb
    begin
        if (req.seed_value <= slrg_pkg::SEED_BASE)
        begin
            diff = slrg_pkg::SEED_BASE - req.seed_value;
        end
        else
        begin
            diff = req.seed_value - slrg_pkg::SEED_BASE;
        end
        if (diff >= {1'b0, slrg_pkg::MODULUS})
        begin
            diff = diff - {1'b0, slrg_pkg::MODULUS};
        end
        cur0 = diff[slrg_pkg::VAL_W-1:0];
    end

    // ring of cells
    genvar j;
    generate
        for (j = 0; j < slrg_pkg::TBL_LEN; j++)
        begin : g_cell
            slrg_pkg::val_t d_step, d_jump;
            if (j == slrg_pkg::TBL_LEN - 1)
            begin : g_tail
                assign d_step = tail_d;
            end
            else
            begin : g_mid
                assign d_step = cells[j + 1];
            end
            if (j == 0)
            begin : g_head
                assign d_jump = head_d;
            end
            else
            begin : g_rest
                assign d_jump = cells[(j + slrg_pkg::JUMP) % slrg_pkg::TBL_LEN];
            end
            slrg_cell u_cell (
                .clk    (clk),
                .op     (op),
                .d_step (d_step),
                .d_jump (d_jump),
                .q      (cells[j])
            );
        end
    endgenerate

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        seeded_next = seeded_reg;
        op          = slrg_pkg::CELL_HOLD;
        tail_d      = draw_val;
        head_d      = cells[slrg_pkg::JUMP];
        load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (need_seed)
                    begin
                        state_next = ST_FILL;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        op       = slrg_pkg::CELL_STEP;
                        load_out = 1'b1;
                    end
                end
            end
            ST_FILL:
            begin
                op     = slrg_pkg::CELL_JUMP;
                head_d = (cnt_reg == '0) ? cur_reg : nxt_reg;
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == FILL_LAST)
                begin
                    state_next = ST_ALNJ;
                end
            end
            ST_ALNJ:
            begin
                op         = slrg_pkg::CELL_JUMP;
                state_next = ST_ALNS;
            end
            ST_ALNS:
            begin
                op         = slrg_pkg::CELL_STEP;
                tail_d     = cells[0];
                state_next = ST_WARM;
                cnt_next   = '0;
            end
            ST_WARM:
            begin
                op       = slrg_pkg::CELL_STEP;
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == WARM_LAST)
                begin
                    state_next  = ST_DRAW;
                    seeded_next = 1'b1;
                end
            end
            ST_DRAW:
            begin
                if (out_free)
                begin
                    op         = slrg_pkg::CELL_STEP;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // fill sequence and result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= draw_val;
        end
        if (accept && need_seed)
        begin
            cur_reg <= cur0;
        end
        else if (state_reg == ST_FILL)
        begin
            if (cnt_reg == '0)
            begin
                nxt_reg <= slrg_pkg::val_t'(1);
            end
            else
            begin
                nxt_reg <= slrg_pkg::sub_wrap(cur_reg, nxt_reg);
                cur_reg <= nxt_reg;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.random_value = out_data_reg;

endmodule
